// File: sv/urs_pkg.sv
// Shared types and constants for the ultrasonic range sequencer.
// No dependencies; used by the core and its checker.
package urs_pkg;

    localparam int PRE_W   = 10;
    localparam int MS_W    = 16;
    localparam int TMR_W   = 17;
    localparam int DIST_W  = 14;
    localparam int REM_W   = 9;
    localparam int CFG_W   = 16;
    localparam int CIDX_W  = 3;

    localparam logic [PRE_W-1:0]  TICKS_PER_MS    = 10'd1000;
    localparam logic [DIST_W-1:0] OUT_OF_RANGE_Q4 = 14'd15984;

    // distance_q4 = floor((t * 80 + 145) / 291), kept as a running quotient
    localparam logic [REM_W:0]   Q_STEP   = 10'd80;
    localparam logic [REM_W:0]   Q_DIV    = 10'd291;
    localparam logic [REM_W-1:0] Q_ROUND  = 9'd145;

    localparam logic [CFG_W-1:0] RST_INTERVAL_MS  = 16'd60;
    localparam logic [7:0]       RST_PULSE_US     = 8'd10;
    localparam logic [CFG_W-1:0] RST_START_TO_US  = 16'd50000;
    localparam logic [CFG_W-1:0] RST_END_TO_US    = 16'd30000;
    localparam logic [9:0]       RST_THRESHOLD_CM = 10'd50;

    typedef enum logic [CIDX_W-1:0] {
        CFG_INTERVAL_MS  = 3'd0,
        CFG_PULSE_US     = 3'd1,
        CFG_START_TO_US  = 3'd2,
        CFG_END_TO_US    = 3'd3,
        CFG_THRESHOLD_CM = 3'd4
    } cfg_idx_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_TRIG = 2'd1,
        PH_WAIT = 2'd2,
        PH_MEAS = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        EV_NONE     = 2'd0,
        EV_MEASURED = 2'd1,
        EV_NO_ECHO  = 2'd2,
        EV_TOO_LONG = 2'd3
    } event_t;

endpackage

// File: sv/ultrasonic_range_sequencer_core.sv
// Ultrasonic ranging controller core: trigger sequencing, echo timing, Q4 distance.
// Depends on urs_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall / echo_level): one beat per microsecond
//   tick carrying the sampled echo pin level.
//   Output channel (out_valid / out_stall / trig_level, distance_q4, obstacle,
//   event_code): exactly one beat per input beat, in order.
//   Config port (cfg_we / cfg_index / cfg_data): writes a register when cfg_we is high;
//   unknown indexes are ignored. Write only while the block is idle.
// Output: a result beat is registered and appears in the cycle after its input beat is taken.
// Throughput: one tick per cycle while in_stall is low; phase, timers and the
// running distance quotient all update together on each accepted tick, the
// distance by one add and compare per tick instead of a divide.
// Reset: phase idle, all timers zero, distance 999 cm (15984), trigger low,
// registers at their default values, output register empty.
// Stall: the output register holds its beat while out_stall is high; in_stall
// rises only when that register is full and stalled, so a new tick is taken
// in the same cycle the held beat leaves.
module ultrasonic_range_sequencer_core
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        echo_level,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        trig_level,
    output logic [urs_pkg::DIST_W-1:0]  distance_q4,
    output logic                        obstacle,
    output logic [1:0]                  event_code,
    input  logic                        cfg_we,
    input  logic [urs_pkg::CIDX_W-1:0]  cfg_index,
    input  logic [urs_pkg::CFG_W-1:0]   cfg_data
);

    logic [urs_pkg::CFG_W-1:0]   interval_ms_reg;
    logic [7:0]                  pulse_us_reg;
    logic [urs_pkg::CFG_W-1:0]   start_to_reg;
    logic [urs_pkg::CFG_W-1:0]   end_to_reg;
    logic [9:0]                  threshold_reg;

    urs_pkg::phase_t             phase_reg, phase_next;
    logic [urs_pkg::PRE_W-1:0]   prescale_reg, prescale_next;
    logic [urs_pkg::MS_W-1:0]    ms_reg, ms_next;
    logic [urs_pkg::TMR_W-1:0]   timer_reg, timer_next;
    logic [urs_pkg::DIST_W-1:0]  dist_reg, dist_next;
    logic                        trig_reg, trig_next;
    logic [urs_pkg::DIST_W-1:0]  quot_reg, quot_next;
    logic [urs_pkg::REM_W-1:0]   rem_reg, rem_next;
    urs_pkg::event_t             event_next;

    logic                        out_valid_reg;
    logic                        out_trig_reg;
    logic [urs_pkg::DIST_W-1:0]  out_dist_reg;
    logic                        out_obst_reg;
    urs_pkg::event_t             out_event_reg;

    logic                        in_accept;
    logic [urs_pkg::PRE_W-1:0]   pre_inc;
    logic                        ms_tick;
    logic [urs_pkg::PRE_W-1:0]   pre_adv;
    logic [urs_pkg::MS_W-1:0]    ms_adv;
    logic [urs_pkg::TMR_W-1:0]   timer_adv;
    logic [urs_pkg::REM_W:0]     rem_sum;
    logic                        rem_carry;
    logic [urs_pkg::REM_W:0]     rem_wrap;
    logic [urs_pkg::REM_W-1:0]   rem_adv;
    logic [urs_pkg::DIST_W-1:0]  quot_adv;
    logic                        obst_next;

    assign in_stall  = out_valid_reg & out_stall;
    assign in_accept = in_valid & ~in_stall;

    // free-running counters, advanced before the phase logic
    always_comb
    begin
        pre_inc   = prescale_reg + 1'b1;
        ms_tick   = (pre_inc >= urs_pkg::TICKS_PER_MS);
        pre_adv   = ms_tick ? '0 : pre_inc;
        ms_adv    = (ms_tick && (ms_reg != '1)) ? ms_reg + 1'b1 : ms_reg;
        timer_adv = (timer_reg != '1) ? timer_reg + 1'b1 : timer_reg;
        rem_sum   = {1'b0, rem_reg} + urs_pkg::Q_STEP;
        rem_carry = (rem_sum >= urs_pkg::Q_DIV);
        rem_wrap  = rem_carry ? rem_sum - urs_pkg::Q_DIV : rem_sum;
        rem_adv   = rem_wrap[urs_pkg::REM_W-1:0];
        quot_adv  = (rem_carry && (quot_reg != '1)) ? quot_reg + 1'b1 : quot_reg;
    end

    always_comb
    begin
        phase_next    = phase_reg;
        prescale_next = pre_adv;
        ms_next       = ms_adv;
        timer_next    = timer_adv;
        dist_next     = dist_reg;
        trig_next     = trig_reg;
        quot_next     = quot_reg;
        rem_next      = rem_reg;
        event_next    = urs_pkg::EV_NONE;
        case (phase_reg)
            urs_pkg::PH_IDLE:
            begin
                if (ms_adv >= interval_ms_reg)
                begin
                    ms_next       = '0;
                    prescale_next = '0;
                    timer_next    = '0;
                    trig_next     = 1'b1;
                    phase_next    = urs_pkg::PH_TRIG;
                end
            end
            urs_pkg::PH_TRIG:
            begin
                if (timer_adv >= {{(urs_pkg::TMR_W-8){1'b0}}, pulse_us_reg})
                begin
                    trig_next  = 1'b0;
                    phase_next = urs_pkg::PH_WAIT;
                end
            end
            urs_pkg::PH_WAIT:
            begin
                if (echo_level)
                begin
                    timer_next = '0;
                    quot_next  = '0;
                    rem_next   = urs_pkg::Q_ROUND;
                    phase_next = urs_pkg::PH_MEAS;
                end
                else if (timer_adv > {1'b0, start_to_reg})
                begin
                    phase_next = urs_pkg::PH_IDLE;
                    event_next = urs_pkg::EV_NO_ECHO;
                end
            end
            urs_pkg::PH_MEAS:
            begin
                quot_next = quot_adv;
                rem_next  = rem_adv;
                if (!echo_level)
                begin
                    dist_next  = quot_adv;
                    phase_next = urs_pkg::PH_IDLE;
                    event_next = urs_pkg::EV_MEASURED;
                end
                else if (timer_adv > {1'b0, end_to_reg})
                begin
                    dist_next  = urs_pkg::OUT_OF_RANGE_Q4;
                    phase_next = urs_pkg::PH_IDLE;
                    event_next = urs_pkg::EV_TOO_LONG;
                end
            end
            default:
            begin
                phase_next = urs_pkg::PH_IDLE;
            end
        endcase
        obst_next = (dist_next != '0) && (dist_next < {threshold_reg, 4'b0000});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_ms_reg <= urs_pkg::RST_INTERVAL_MS;
            pulse_us_reg    <= urs_pkg::RST_PULSE_US;
            start_to_reg    <= urs_pkg::RST_START_TO_US;
            end_to_reg      <= urs_pkg::RST_END_TO_US;
            threshold_reg   <= urs_pkg::RST_THRESHOLD_CM;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                urs_pkg::CFG_INTERVAL_MS:  interval_ms_reg <= cfg_data;
                urs_pkg::CFG_PULSE_US:     pulse_us_reg    <= cfg_data[7:0];
                urs_pkg::CFG_START_TO_US:  start_to_reg    <= cfg_data;
                urs_pkg::CFG_END_TO_US:    end_to_reg      <= cfg_data;
                urs_pkg::CFG_THRESHOLD_CM: threshold_reg   <= cfg_data[9:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= urs_pkg::PH_IDLE;
            prescale_reg <= '0;
            ms_reg       <= '0;
            timer_reg    <= '0;
            dist_reg     <= urs_pkg::OUT_OF_RANGE_Q4;
            trig_reg     <= 1'b0;
            quot_reg     <= '0;
            rem_reg      <= urs_pkg::Q_ROUND;
        end
        else if (in_accept)
        begin
            phase_reg    <= phase_next;
            prescale_reg <= prescale_next;
            ms_reg       <= ms_next;
            timer_reg    <= timer_next;
            dist_reg     <= dist_next;
            trig_reg     <= trig_next;
            quot_reg     <= quot_next;
            rem_reg      <= rem_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_trig_reg  <= trig_next;
            out_dist_reg  <= dist_next;
            out_obst_reg  <= obst_next;
            out_event_reg <= event_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign trig_level  = out_trig_reg;
    assign distance_q4 = out_dist_reg;
    assign obstacle    = out_obst_reg;
    assign event_code  = out_event_reg;

endmodule

// File: sv/urs_checker.sv
// Port-level checks for ultrasonic_range_sequencer_core, attached by bind.
// Depends on urs_pkg.
module urs_checker
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  logic                        trig_level,
    input  logic [urs_pkg::DIST_W-1:0]  distance_q4,
    input  logic                        obstacle,
    input  logic [1:0]                  event_code
);

    // a held beat keeps its distance and event code
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(distance_q4) && $stable(event_code))
        else $error("stalled output beat changed");

    // every accepted tick yields a result beat next cycle
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid)
        else $error("accepted tick produced no result");

    a_obst_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && obstacle |-> distance_q4 != '0)
        else $error("obstacle with zero distance");

    a_too_long: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_code == urs_pkg::EV_TOO_LONG)
            |-> distance_q4 == urs_pkg::OUT_OF_RANGE_Q4)
        else $error("long echo without out-of-range distance");

    a_meas_trig_low: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_code == urs_pkg::EV_MEASURED || event_code == urs_pkg::EV_NO_ECHO)
            |-> !trig_level)
        else $error("trigger high at end of measurement");

endmodule

bind ultrasonic_range_sequencer_core urs_checker u_urs_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .trig_level  (trig_level),
    .distance_q4 (distance_q4),
    .obstacle    (obstacle),
    .event_code  (event_code)
);
